// ----- sv/orl_pkg.sv -----
// Shared types and constants for the object record loader.
`timescale 1ns / 1ps
package orl_pkg;

  localparam int IDX_W = 26;

  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_ALPHA_OFS = 8'd55;
  localparam logic [7:0] CH_T         = 8'h54;
  localparam logic [7:0] CH_M         = 8'h4D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [8:0] HEADER_LEN   = 9'd19;
  localparam logic [8:0] START_FIRST  = 9'd7;
  localparam logic [8:0] START_LAST   = 9'd12;
  localparam logic [8:0] ADDR_DIGITS  = 9'd6;
  localparam logic [8:0] LEN_DIGITS   = 9'd2;
  localparam logic [13:0] LOAD_ADDRESS_RESET = 14'd1024;

  typedef enum logic [1:0] {
    EV_NIBBLE  = 2'd0,
    EV_XFER    = 2'd1,
    EV_DROPPED = 2'd2
  } event_kind_t;

  typedef enum logic [3:0] {
    PH_HEADER, PH_SKIP, PH_DISPATCH, PH_T_ADDR, PH_T_LEN, PH_T_TEXT,
    PH_M_ADDR, PH_M_LEN, PH_E_ADDR, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PARSE, S_MREAD, S_MADD, S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic clear_step;
    logic load_char;
    logic parse;
    logic mod_read;
    logic mod_add;
    logic emit;
  } orl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic step_emit;
    logic step_modify;
    logic mod_more;
    logic out_free;
  } orl_status_t;

endpackage

// ----- sv/orl_ctrl.sv -----
// Sequencing state machine of the object record loader.
`timescale 1ns / 1ps
module orl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  orl_pkg::orl_status_t status,
  output orl_pkg::orl_cmd_t    cmd
);

  orl_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= orl_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      orl_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = orl_pkg::S_IDLE;
      end
      orl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_char = 1'b1;
          state_next = orl_pkg::S_PARSE;
        end
      end
      orl_pkg::S_PARSE: begin
        cmd.parse = 1'b1;
        if (status.step_emit) state_next = orl_pkg::S_EMIT;
        else if (status.step_modify) state_next = orl_pkg::S_MREAD;
        else state_next = orl_pkg::S_IDLE;
      end
      orl_pkg::S_MREAD: begin
        cmd.mod_read = 1'b1;
        state_next = orl_pkg::S_MADD;
      end
      orl_pkg::S_MADD: begin
        cmd.mod_add = 1'b1;
        state_next = orl_pkg::S_EMIT;
      end
      orl_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = status.mod_more ? orl_pkg::S_MREAD : orl_pkg::S_IDLE;
        end
      end
      default: state_next = orl_pkg::S_CLEAR;
    endcase
  end

endmodule

// ----- sv/orl_datapath.sv -----
// Parser registers, nibble store and output register of the object record loader.
`timescale 1ns / 1ps
module orl_datapath #(
  parameter int MEM_NIBBLES        = 32768,
  parameter int MAX_MODIFY_NIBBLES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  orl_pkg::orl_cmd_t    cmd,
  output orl_pkg::orl_status_t status,
  input  logic [7:0]           in_char,
  input  logic                 in_sof,
  input  logic                 cfg_valid,
  input  logic [13:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [14:0]          out_addr,
  output logic [3:0]           out_value,
  output logic [23:0]          out_xfer,
  output logic                 out_reloc,
  output logic                 out_last
);

  localparam int AW = $clog2(MEM_NIBBLES);
  localparam int CW = $clog2(MAX_MODIFY_NIBBLES + 1);
  localparam int IW = orl_pkg::IDX_W;

  logic [3:0]  mem [MEM_NIBBLES];
  logic [3:0]  rd_data;
  logic [AW-1:0] clr_addr;

  logic [13:0] load_address;
  logic [7:0]  c;
  logic        sof;
  orl_pkg::phase_t phase, phase_next;
  logic [8:0]  cnt, cnt_next;
  logic [23:0] acc, acc_next;
  logic [23:0] rec_addr, rec_addr_next;
  logic [7:0]  rec_len, rec_len_next;
  logic [23:0] base, base_next;
  logic        reloc, reloc_next;

  logic [1:0]  pend_kind, pk_next;
  logic [IW-1:0] pend_idx, pi_next;
  logic [3:0]  pend_val, pv_next;
  logic [23:0] pend_xfer, px_next;
  logic        pend_last;

  logic [CW-1:0] mod_count, mc_next;
  logic [IW-1:0] mod_idx, mi_next;
  logic [23:0] mod_base;
  logic        mod_carry;

  logic        step_emit, step_modify;
  logic [3:0]  d;
  orl_pkg::phase_t ph;
  logic [8:0]  cn;
  logic [23:0] ac;
  logic [23:0] rbase;
  logic [IW-1:0] twice_addr;
  logic [7:0]  mlen;
  logic [3:0]  mv;
  logic [4:0]  msum;

  assign d = (c <= orl_pkg::CH_9) ? 4'(c - orl_pkg::CH_0) : 4'(c - orl_pkg::CH_ALPHA_OFS);
  assign rbase = reloc ? base : 24'd0;
  assign twice_addr = {1'b0, rec_addr, 1'b0};

  always_comb begin
    ph = sof ? orl_pkg::PH_HEADER : phase;
    cn = sof ? 9'd0 : cnt;
    ac = sof ? 24'd0 : acc;
    phase_next = ph;
    cnt_next = cn;
    acc_next = ac;
    rec_addr_next = rec_addr;
    rec_len_next = rec_len;
    base_next = base;
    reloc_next = reloc;
    step_emit = 1'b0;
    step_modify = 1'b0;
    pk_next = orl_pkg::EV_NIBBLE;
    pi_next = '0;
    pv_next = '0;
    px_next = '0;
    mc_next = '0;
    mi_next = '0;
    mlen = '0;
    case (ph)
      orl_pkg::PH_HEADER: begin
        if (cn >= orl_pkg::START_FIRST && cn <= orl_pkg::START_LAST) acc_next = {ac[19:0], d};
        cnt_next = cn + 9'd1;
        if (cnt_next >= orl_pkg::HEADER_LEN) begin
          reloc_next = (acc_next == 24'd0);
          base_next = reloc_next ? {10'd0, load_address} : acc_next;
          phase_next = orl_pkg::PH_SKIP;
          cnt_next = '0;
          acc_next = '0;
        end
      end
      orl_pkg::PH_SKIP: begin
        if (c == orl_pkg::CH_LF) phase_next = orl_pkg::PH_DISPATCH;
      end
      orl_pkg::PH_DISPATCH: begin
        if (c == orl_pkg::CH_T) phase_next = orl_pkg::PH_T_ADDR;
        else if (c == orl_pkg::CH_M) phase_next = orl_pkg::PH_M_ADDR;
        else phase_next = orl_pkg::PH_E_ADDR;
        cnt_next = '0;
        acc_next = '0;
      end
      orl_pkg::PH_T_ADDR, orl_pkg::PH_M_ADDR, orl_pkg::PH_E_ADDR: begin
        acc_next = {ac[19:0], d};
        cnt_next = cn + 9'd1;
        if (cnt_next >= orl_pkg::ADDR_DIGITS) begin
          cnt_next = '0;
          rec_len_next = '0;
          if (ph == orl_pkg::PH_E_ADDR) begin
            step_emit = 1'b1;
            pk_next = orl_pkg::EV_XFER;
            px_next = acc_next + rbase;
            phase_next = orl_pkg::PH_DONE;
            rec_len_next = rec_len;
          end else if (ph == orl_pkg::PH_T_ADDR) begin
            rec_addr_next = acc_next + rbase;
            phase_next = orl_pkg::PH_T_LEN;
          end else begin
            rec_addr_next = acc_next + base;
            phase_next = orl_pkg::PH_M_LEN;
          end
        end
      end
      orl_pkg::PH_T_LEN: begin
        rec_len_next = {rec_len[3:0], d};
        cnt_next = cn + 9'd1;
        if (cnt_next >= orl_pkg::LEN_DIGITS) begin
          cnt_next = '0;
          phase_next = (rec_len_next != 8'd0) ? orl_pkg::PH_T_TEXT : orl_pkg::PH_SKIP;
        end
      end
      orl_pkg::PH_T_TEXT: begin
        step_emit = 1'b1;
        pi_next = twice_addr + IW'(cn);
        pk_next = (pi_next < IW'(MEM_NIBBLES)) ? orl_pkg::EV_NIBBLE : orl_pkg::EV_DROPPED;
        pv_next = d;
        cnt_next = cn + 9'd1;
        if (cnt_next >= {rec_len, 1'b0}) begin
          cnt_next = '0;
          phase_next = orl_pkg::PH_SKIP;
        end
      end
      orl_pkg::PH_M_LEN: begin
        rec_len_next = {rec_len[3:0], d};
        cnt_next = cn + 9'd1;
        if (cnt_next >= orl_pkg::LEN_DIGITS) begin
          mlen = (rec_len_next > 8'(MAX_MODIFY_NIBBLES)) ? 8'(MAX_MODIFY_NIBBLES)
                                                           : rec_len_next;
          step_modify = (mlen != 8'd0);
          mc_next = CW'(mlen);
          mi_next = twice_addr + IW'(rec_len_next[0]) + IW'(mlen) - IW'(1);
          cnt_next = '0;
          phase_next = orl_pkg::PH_SKIP;
        end
      end
      default: ;
    endcase
  end

  assign mv = (mod_idx < IW'(MEM_NIBBLES)) ? rd_data : 4'hF;
  assign msum = {1'b0, mv} + {1'b0, mod_base[3:0]} + {4'd0, mod_carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      load_address <= orl_pkg::LOAD_ADDRESS_RESET;
      phase <= orl_pkg::PH_HEADER;
      cnt <= '0;
      acc <= '0;
      rec_addr <= '0;
      rec_len <= '0;
      base <= '0;
      reloc <= 1'b0;
      mod_count <= '0;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) load_address <= cfg_data;
      if (cmd.clear_step) clr_addr <= clr_addr + AW'(1);
      if (cmd.load_char) begin
        c <= in_char;
        sof <= in_sof;
      end
      if (cmd.parse) begin
        phase <= phase_next;
        cnt <= cnt_next;
        acc <= acc_next;
        rec_addr <= rec_addr_next;
        rec_len <= rec_len_next;
        base <= base_next;
        reloc <= reloc_next;
        pend_kind <= pk_next;
        pend_idx <= pi_next;
        pend_val <= pv_next;
        pend_xfer <= px_next;
        pend_last <= 1'b1;
        if (step_modify) begin
          mod_count <= mc_next;
          mod_idx <= mi_next;
          mod_base <= base;
          mod_carry <= 1'b0;
        end
      end
      if (cmd.mod_add) begin
        pend_kind <= (mod_idx < IW'(MEM_NIBBLES)) ? orl_pkg::EV_NIBBLE : orl_pkg::EV_DROPPED;
        pend_idx <= mod_idx;
        pend_val <= msum[3:0];
        pend_xfer <= '0;
        pend_last <= (mod_count == CW'(1));
        mod_carry <= msum[4];
        mod_base <= {4'd0, mod_base[23:4]};
        mod_idx <= mod_idx - IW'(1);
        mod_count <= mod_count - CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_kind <= pend_kind;
        out_addr <= pend_idx[14:0];
        out_value <= pend_val;
        out_xfer <= pend_xfer;
        out_reloc <= reloc;
        out_last <= pend_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_addr] <= 4'hF;
    end else if (cmd.emit && pend_kind == orl_pkg::EV_NIBBLE) begin
      mem[pend_idx[AW-1:0]] <= pend_val;
    end
    if (cmd.mod_read) rd_data <= mem[mod_idx[AW-1:0]];
  end

  assign status.clear_done  = (clr_addr == AW'(MEM_NIBBLES - 1));
  assign status.step_emit   = step_emit;
  assign status.step_modify = step_modify;
  assign status.mod_more    = (mod_count != '0);
  assign status.out_free    = !out_valid || out_ready;

endmodule

// ----- sv/object_record_loader_unit.sv -----
// Top level of the object record loader: stream ports, controller and datapath.
//
// The slave stream carries one object file character per transaction; tuser
// set restarts header parsing with that character. The master stream carries
// one load event per transaction, with tlast on the last event a character
// causes. The cfg channel writes the load address used for relocatable
// programs; it is always ready and takes effect at the next header.
// After reset the nibble store is swept to all ones, one entry per cycle; no
// character is taken during that sweep.
// A character that causes no event is accepted and parsed. A text character is
// accepted, parsed and loaded into the output register. For a modification
// record's length character the single store read port sets the order: each
// digit is read, added and written back in turn.
// The output register holds one event; when the receiver stalls, the
// controller waits with the next event and takes no new character.
`timescale 1ns / 1ps
module object_record_loader_unit #(
  parameter int MEM_NIBBLES        = 32768,
  parameter int MAX_MODIFY_NIBBLES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  input  logic [0:0]  s_tuser,   // start_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // nibble_address, nibble_value, transfer_address, relocated
  output logic [1:0]  m_tuser,   // event_kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data
);

  orl_pkg::orl_cmd_t    cmd;
  orl_pkg::orl_status_t status;
  logic [14:0] out_addr;
  logic [3:0]  out_value;
  logic [23:0] out_xfer;
  logic        out_reloc;

  assign cfg_ready = 1'b1;

  orl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .status(status), .cmd(cmd)
  );

  orl_datapath #(
    .MEM_NIBBLES(MEM_NIBBLES), .MAX_MODIFY_NIBBLES(MAX_MODIFY_NIBBLES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_char(s_tdata), .in_sof(s_tuser[0]),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_kind(m_tuser),
    .out_addr(out_addr), .out_value(out_value), .out_xfer(out_xfer),
    .out_reloc(out_reloc), .out_last(m_tlast)
  );

  assign m_tdata = {4'd0, out_reloc, out_xfer, out_value, out_addr};

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == orl_pkg::EV_NIBBLE || m_tuser == orl_pkg::EV_XFER ||
                  m_tuser == orl_pkg::EV_DROPPED))
    else $error("undefined event kind on output");

  a_xfer_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == orl_pkg::EV_XFER |-> m_tdata[18:0] == 19'd0 && m_tlast)
    else $error("transfer event carries nibble fields or lacks tlast");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !s_tready)
    else $error("character accepted while an event is pending");

endmodule

// ----- tb/sv/object_record_loader_unit_tb.sv -----
// Self-checking testbench for the object record loader: directed table, random object files.
`timescale 1ns / 1ps
module object_record_loader_unit_tb;

  localparam int STORE_NIBBLES = 32768;
  localparam int MOD_LIMIT     = 8;
  localparam int STALL_LIMIT   = 100000;

  typedef struct {
    logic [7:0]           code;
    logic                 sof;
    logic                 check;
    orl_pkg::event_kind_t kind;
    logic [23:0]          xfer;
  } char_item_t;

  typedef struct {
    orl_pkg::event_kind_t kind;
    logic [14:0]          naddr;
    logic [3:0]           nval;
    logic [23:0]          xfer;
    logic                 reloc;
    logic                 last;
  } load_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [13:0] cfg_data = '0;

  always #1 clk = ~clk;

  object_record_loader_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  char_item_t  char_q[$];
  load_event_t event_q[$];
  char_item_t  cur_char;
  int          fail_count = 0;
  int          chars_sent = 0;
  bit          no_idle = 1'b0;
  int          stall_cycles = 0;

  // Predictor state.
  logic [13:0]      p_load_addr = orl_pkg::LOAD_ADDRESS_RESET;
  orl_pkg::phase_t  p_phase = orl_pkg::PH_HEADER;
  logic [8:0]       p_count = '0;
  logic [23:0]      p_acc = '0;
  logic [23:0]      p_rec_addr = '0;
  logic [7:0]       p_rec_len = '0;
  logic [23:0]      p_base = '0;
  logic             p_reloc = 1'b0;
  logic [3:0]       p_store [STORE_NIBBLES];

  initial for (int i = 0; i < STORE_NIBBLES; i++) p_store[i] = 4'hF;

  function automatic logic [3:0] digit_of(logic [7:0] c);
    logic [7:0] t;
    t = (c <= orl_pkg::CH_9) ? c - orl_pkg::CH_0 : c - orl_pkg::CH_ALPHA_OFS;
    return t[3:0];
  endfunction

  task automatic push_event(orl_pkg::event_kind_t k, logic [63:0] a, logic [3:0] v,
                            logic [23:0] x);
    load_event_t e;
    e.kind = k; e.naddr = a[14:0]; e.nval = v; e.xfer = x; e.reloc = p_reloc; e.last = 1'b0;
    event_q.push_back(e);
  endtask

  task automatic predict_char(logic [7:0] c, logic sof);
    logic [3:0]  d;
    logic [23:0] rb, b;
    logic [63:0] idx, start;
    logic [4:0]  s;
    logic [3:0]  v;
    logic        carry;
    int          n, len;
    d = digit_of(c);
    n = event_q.size();
    rb = p_reloc ? p_base : 24'd0;
    if (sof) begin
      p_phase = orl_pkg::PH_HEADER; p_count = '0; p_acc = '0;
    end
    case (p_phase)
      orl_pkg::PH_HEADER: begin
        if (p_count >= orl_pkg::START_FIRST && p_count <= orl_pkg::START_LAST)
          p_acc = {p_acc[19:0], d};
        p_count++;
        if (p_count >= orl_pkg::HEADER_LEN) begin
          p_reloc = (p_acc == 24'd0);
          p_base = p_reloc ? {10'd0, p_load_addr} : p_acc;
          p_phase = orl_pkg::PH_SKIP; p_count = '0; p_acc = '0;
        end
      end
      orl_pkg::PH_SKIP: if (c == orl_pkg::CH_LF) p_phase = orl_pkg::PH_DISPATCH;
      orl_pkg::PH_DISPATCH: begin
        p_phase = (c == orl_pkg::CH_T) ? orl_pkg::PH_T_ADDR :
                  (c == orl_pkg::CH_M) ? orl_pkg::PH_M_ADDR : orl_pkg::PH_E_ADDR;
        p_count = '0; p_acc = '0;
      end
      orl_pkg::PH_T_ADDR, orl_pkg::PH_M_ADDR, orl_pkg::PH_E_ADDR: begin
        p_acc = {p_acc[19:0], d};
        p_count++;
        if (p_count >= orl_pkg::ADDR_DIGITS) begin
          p_count = '0;
          if (p_phase == orl_pkg::PH_E_ADDR) begin
            push_event(orl_pkg::EV_XFER, 64'd0, 4'd0, p_acc + rb);
            p_phase = orl_pkg::PH_DONE;
          end else begin
            b = (p_phase == orl_pkg::PH_T_ADDR) ? rb : p_base;
            p_rec_addr = p_acc + b;
            p_rec_len = '0;
            p_phase = (p_phase == orl_pkg::PH_T_ADDR) ? orl_pkg::PH_T_LEN : orl_pkg::PH_M_LEN;
          end
        end
      end
      orl_pkg::PH_T_LEN: begin
        p_rec_len = {p_rec_len[3:0], d};
        p_count++;
        if (p_count >= orl_pkg::LEN_DIGITS) begin
          p_count = '0;
          p_phase = (p_rec_len != 8'd0) ? orl_pkg::PH_T_TEXT : orl_pkg::PH_SKIP;
        end
      end
      orl_pkg::PH_T_TEXT: begin
        idx = 64'd2 * 64'(p_rec_addr) + 64'(p_count);
        if (idx < 64'(STORE_NIBBLES)) begin
          p_store[idx] = d;
          push_event(orl_pkg::EV_NIBBLE, idx, d, 24'd0);
        end else begin
          push_event(orl_pkg::EV_DROPPED, idx, d, 24'd0);
        end
        p_count++;
        if (32'(p_count) >= 2 * 32'(p_rec_len)) begin
          p_count = '0; p_phase = orl_pkg::PH_SKIP;
        end
      end
      orl_pkg::PH_M_LEN: begin
        p_rec_len = {p_rec_len[3:0], d};
        p_count++;
        if (p_count >= orl_pkg::LEN_DIGITS) begin
          len = (int'(p_rec_len) > MOD_LIMIT) ? MOD_LIMIT : int'(p_rec_len);
          start = 64'd2 * 64'(p_rec_addr) + 64'(p_rec_len[0]);
          b = p_base;
          carry = 1'b0;
          for (int i = 0; i < len; i++) begin
            idx = start + 64'(len - 1 - i);
            v = (idx < 64'(STORE_NIBBLES)) ? p_store[idx] : 4'hF;
            s = 5'(v) + 5'(b[3:0]) + 5'(carry);
            b = b >> 4;
            carry = s[4];
            if (idx < 64'(STORE_NIBBLES)) begin
              p_store[idx] = s[3:0];
              push_event(orl_pkg::EV_NIBBLE, idx, s[3:0], 24'd0);
            end else begin
              push_event(orl_pkg::EV_DROPPED, idx, s[3:0], 24'd0);
            end
          end
          p_count = '0; p_phase = orl_pkg::PH_SKIP;
        end
      end
      default: ;
    endcase
    if (event_q.size() > n) event_q[$].last = 1'b1;
  endtask

  // Character driver; prediction happens at each accepted transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_char(cur_char.code, cur_char.sof);
        chars_sent++;
        if (cur_char.check) begin
          if (event_q.size() == 0) begin
            $error("event_kind expected %0d actual none", cur_char.kind);
            fail_count++;
          end else begin
            if (event_q[$].kind != cur_char.kind) begin
              $error("event_kind expected %0d actual %0d", cur_char.kind, event_q[$].kind);
              fail_count++;
            end
            if (event_q[$].xfer != cur_char.xfer) begin
              $error("transfer_address expected %h actual %h", cur_char.xfer,
                     event_q[$].xfer);
              fail_count++;
            end
          end
        end
      end
      if (!s_tvalid || s_tready) begin
        if (char_q.size() > 0 && (no_idle || $urandom_range(99) >= 16)) begin
          cur_char = char_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_char.code;
          s_tuser  <= cur_char.sof;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Event checker.
  always @(posedge clk) begin
    load_event_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (event_q.size() == 0) begin
          $error("unexpected event: tuser %h tdata %h", m_tuser, m_tdata);
          fail_count++;
        end else begin
          e = event_q.pop_front();
          if (m_tuser !== e.kind) begin
            $error("event_kind expected %0d actual %0d", e.kind, m_tuser); fail_count++;
          end
          if (m_tdata[14:0] !== e.naddr) begin
            $error("nibble_address expected %h actual %h", e.naddr, m_tdata[14:0]);
            fail_count++;
          end
          if (m_tdata[18:15] !== e.nval) begin
            $error("nibble_value expected %h actual %h", e.nval, m_tdata[18:15]);
            fail_count++;
          end
          if (m_tdata[42:19] !== e.xfer) begin
            $error("transfer_address expected %h actual %h", e.xfer, m_tdata[42:19]);
            fail_count++;
          end
          if (m_tdata[43] !== e.reloc) begin
            $error("relocated expected %b actual %b", e.reloc, m_tdata[43]); fail_count++;
          end
          if (m_tlast !== e.last) begin
            $error("last_of_run expected %b actual %b", e.last, m_tlast); fail_count++;
          end
        end
      end
      m_tready <= no_idle || ($urandom_range(99) >= 16);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_char(logic [7:0] c, logic sof);
    char_item_t it;
    it.code = c; it.sof = sof; it.check = 1'b0; it.kind = orl_pkg::EV_NIBBLE; it.xfer = '0;
    char_q.push_back(it);
  endtask

  task automatic push_hex(logic [23:0] val, int digits, bit lower);
    logic [3:0] d;
    for (int i = digits - 1; i >= 0; i--) begin
      d = 4'(val >> (4 * i));
      if (d < 4'd10) push_char(orl_pkg::CH_0 + 8'(d), 1'b0);
      else push_char((lower ? 8'h61 : 8'h41) + 8'(d) - 8'd10, 1'b0);
    end
  endtask

  task automatic wait_drained();
    wait (char_q.size() == 0 && !s_tvalid && event_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_load_addr(logic [13:0] v);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    p_load_addr = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic gen_file();
    bit          lc;
    int          nrec, sel;
    logic [23:0] st, ad;
    logic [7:0]  ln;
    lc = ($urandom_range(3) == 0);
    push_char(8'h48, 1'b1);
    repeat (6) push_char(8'($urandom_range(32, 126)), 1'b0);
    case ($urandom_range(3))
      0, 1: st = 24'd0;
      2: st = 24'($urandom_range(1, 4000));
      default: st = $urandom_range(1) ? 24'hFFFFFF : 24'($urandom);
    endcase
    push_hex(st, 6, lc);
    push_hex(24'($urandom), 6, lc);
    if ($urandom_range(3) == 0) push_char(8'($urandom_range(32, 126)), 1'b0);
    nrec = $urandom_range(1, 4);
    for (int r = 0; r < nrec; r++) begin
      push_char(orl_pkg::CH_LF, 1'b0);
      sel = $urandom_range(9);
      ad = ($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
      if (sel < 5) begin
        push_char(orl_pkg::CH_T, 1'b0);
        push_hex(ad, 6, lc);
        ln = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
        push_hex({16'd0, ln}, 2, lc);
        repeat (2 * ln) push_hex(24'($urandom), 1, lc);
      end else begin
        push_char(orl_pkg::CH_M, 1'b0);
        push_hex(ad, 6, lc);
        ln = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 12));
        push_hex({16'd0, ln}, 2, lc);
      end
    end
    push_char(orl_pkg::CH_LF, 1'b0);
    push_char($urandom_range(1) ? 8'h45 : 8'($urandom_range(0, 255)), 1'b0);
    push_hex(24'($urandom), 6, lc);
    repeat ($urandom_range(0, 3)) push_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  localparam int N_ROWS = 27;
  char_item_t table_rows [N_ROWS];

  initial begin
    string hdr;
    int    f;
    hdr = "HPROG01000000000100\nE000010";
    for (int i = 0; i < N_ROWS; i++) begin
      table_rows[i].code  = hdr[i];
      table_rows[i].sof   = (i == 0);
      table_rows[i].check = (i == N_ROWS - 1);
      table_rows[i].kind  = orl_pkg::EV_XFER;
      table_rows[i].xfer  = 24'h000410;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    no_idle = 1'b1;
    foreach (table_rows[i]) char_q.push_back(table_rows[i]);
    wait_drained();
    no_idle = 1'b0;
    f = 0;
    while (chars_sent < 400) begin
      if (f % 3 == 0) begin
        case ((f / 3) % 4)
          0: write_load_addr(14'd0);
          1: write_load_addr(14'h3FFF);
          default: write_load_addr(14'($urandom_range(0, 2000)));
        endcase
      end
      no_idle = (f >= 4 && f < 7);
      if ($urandom_range(9) == 0) begin
        repeat (15) push_char(8'($urandom_range(0, 255)), $urandom_range(15) == 0);
      end else begin
        gen_file();
      end
      wait (char_q.size() == 0);
      f++;
    end
    wait_drained();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/orl_pkg.sv
sv/orl_ctrl.sv
sv/orl_datapath.sv
sv/object_record_loader_unit.sv
tb/sv/object_record_loader_unit_tb.sv
